// ===== sv/raster_crop_pad_vertical_align_assert.svh =====
// Assertion macros used by the checker of this block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef RASTER_CROP_PAD_VERTICAL_ALIGN_ASSERT_SVH
`define RASTER_CROP_PAD_VERTICAL_ALIGN_ASSERT_SVH

// same-cycle implication
`define RCPVA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcpva assertion failed");

// next-cycle implication
`define RCPVA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcpva assertion failed");

`endif

// ===== sv/rcpva_pkg.sv =====
package rcpva_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W = 13;
	localparam int POS_W = $clog2(MAX_DIM);
	localparam int PIX_W = 32;
	localparam int CNT_W = 25;
	localparam int IDX_W = 3;
	localparam int ALIGN_W = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int SETTLE = 4;
	localparam int SET_W = $clog2(SETTLE + 1);

	localparam logic [PIX_W-1:0] PAD_ZERO = 32'h0000_0000;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [ALIGN_W-1:0] ALIGN_TOP    = 2'd0;
	localparam logic [ALIGN_W-1:0] ALIGN_CENTER = 2'd1;
	localparam logic [ALIGN_W-1:0] ALIGN_BOTTOM = 2'd2;

	// one-hot run kinds, in emission order
	localparam logic [3:0] RUN_TOP  = 4'b0001;
	localparam logic [3:0] RUN_PIX  = 4'b0010;
	localparam logic [3:0] RUN_RPAD = 4'b0100;
	localparam logic [3:0] RUN_BOT  = 4'b1000;

	typedef enum logic [IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_VERT_ALIGN = 3'd4,
		REG_FILL_COLOR = 3'd5,
		REG_IS_ARGB    = 3'd6
	} reg_idx_t;

	// classified pixel: which runs it causes
	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             top;
		logic             pix;
		logic             pix_done;
		logic             rpad;
		logic             rpad_done;
		logic             bot;
	} entry_t;

	// frame geometry the back end needs to build runs
	typedef struct packed {
		logic [PIX_W-1:0] pad_value;
		logic [CNT_W-1:0] top_count;
		logic [CNT_W-1:0] bot_count;
		logic [DIM_W-1:0] rpad;
	} geom_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

// ===== sv/raster_crop_pad_vertical_align.sv =====
// Raster crop / pad with vertical alignment.
// Source pixels enter on the pix channel (pix_valid, pix_stall, pixel) in
// raster order; the resized frame leaves on the run channel as runs of
// run_value repeated run_count times. last_of_item flags the last run caused
// by one pixel, frame_done the run that closes the output frame.
// Registers are written through wr_en / wr_index / wr_data while idle; each
// write holds pix_stall high while the geometry pipeline settles.
// Throughput: one pixel per cycle. A pixel causes up to four runs and the
// run side builds one run per cycle, so pixels that cause several runs fill
// the 4-entry queue between the front and back ends, and pix_stall rises
// when it is full. A pixel's first run passes through the queue and then the
// output register before it is offered. While run_stall is high the output
// run holds and the queue keeps taking pixels until full. Reset clears the
// raster position, the queue and the output register, loads the register
// defaults and stalls input while the geometry pipeline settles.
module raster_crop_pad_vertical_align (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [rcpva_pkg::IDX_W-1:0] wr_index,
	input  logic [rcpva_pkg::PIX_W-1:0] wr_data,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  logic [rcpva_pkg::PIX_W-1:0] pixel,
	output logic                        run_valid,
	input  logic                        run_stall,
	output logic [rcpva_pkg::PIX_W-1:0] run_value,
	output logic [rcpva_pkg::CNT_W-1:0] run_count,
	output logic                        last_of_item,
	output logic                        frame_done
);
	import rcpva_pkg::*;

	logic   push, pop, empty, full;
	entry_t push_entry, head;
	geom_t  geom;

	rcpva_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.pix_valid  (pix_valid),
		.pixel      (pixel),
		.pix_stall  (pix_stall),
		.full       (full),
		.push       (push),
		.push_entry (push_entry),
		.geom       (geom)
	);

	rcpva_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	rcpva_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.run_valid    (run_valid),
		.run_stall    (run_stall),
		.run_value    (run_value),
		.run_count    (run_count),
		.last_of_item (last_of_item),
		.frame_done   (frame_done)
	);

endmodule

// ===== sv/rcpva_front.sv =====
module rcpva_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rcpva_pkg::IDX_W-1:0]   wr_index,
	input  logic [rcpva_pkg::PIX_W-1:0]   wr_data,
	input  logic                          pix_valid,
	input  logic [rcpva_pkg::PIX_W-1:0]   pixel,
	output logic                          pix_stall,
	input  logic                          full,
	output logic                          push,
	output rcpva_pkg::entry_t             push_entry,
	output rcpva_pkg::geom_t              geom
);
	import rcpva_pkg::*;

	logic [DIM_W-1:0]   src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [ALIGN_W-1:0] align_q;
	logic [PIX_W-1:0]   fill_q;
	logic               argb_q;
	logic [SET_W-1:0]   settle_q;

	logic [DIM_W-1:0]   sw_s1, sh_s1, dw_s1, dh_s1;
	logic [ALIGN_W-1:0] align_s1;
	logic [PIX_W-1:0]   padv_s1;
	logic               argb_s1;

	logic [DIM_W-1:0]   sw_s2, sh_s2, dw_s2, kw_s2, rpad_s2, vdiff_s2, kept_s2;
	logic               crop_s2;
	logic [ALIGN_W-1:0] align_s2;
	logic [PIX_W-1:0]   padv_s2;
	logic               argb_s2;

	logic [DIM_W-1:0]   sw_s3, sh_s3, dw_s3, kw_m1_s3, rpad_s3;
	logic [DIM_W-1:0]   first_s3, last_row_s3, top_s3, bot_s3;
	logic [PIX_W-1:0]   padv_s3;
	logic               argb_s3;

	logic [CNT_W-1:0]   top_cnt_s4, bot_cnt_s4;

	logic [POS_W-1:0]   col_q, row_q;

	logic [DIM_W-1:0]   shift;
	logic [2*DIM_W-1:0] top_prod, bot_prod;
	logic [DIM_W-1:0]   col_w, row_w, c0, r0a, r0, c1, r1;
	logic               keep_row, keep_col, last_col, last_row;
	logic               top_nz, rpad_nz, bot_nz;
	logic               accept;
	entry_t             e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= DIM_W'(1);
			src_h_q  <= DIM_W'(1);
			dst_w_q  <= DIM_W'(1);
			dst_h_q  <= DIM_W'(1);
			align_q  <= ALIGN_TOP;
			fill_q   <= PAD_ZERO;
			argb_q   <= 1'b1;
			settle_q <= SET_W'(SETTLE);
		end else begin
			if (wr_en) begin
				settle_q <= SET_W'(SETTLE);
				case (wr_index)
					REG_SRC_WIDTH:  src_w_q <= wr_data[DIM_W-1:0];
					REG_SRC_HEIGHT: src_h_q <= wr_data[DIM_W-1:0];
					REG_DST_WIDTH:  dst_w_q <= wr_data[DIM_W-1:0];
					REG_DST_HEIGHT: dst_h_q <= wr_data[DIM_W-1:0];
					REG_VERT_ALIGN: align_q <= wr_data[ALIGN_W-1:0];
					REG_FILL_COLOR: fill_q  <= wr_data;
					REG_IS_ARGB:    argb_q  <= wr_data[0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SET_W'(1);
			end
		end
	end

	// geometry pipeline, recomputed every cycle from the registers
	always_comb begin
		if (align_s2 == ALIGN_CENTER)
			shift = vdiff_s2 >> 1;
		else if (align_s2 == ALIGN_BOTTOM)
			shift = vdiff_s2;
		else
			shift = '0;
	end

	assign top_prod = {{DIM_W{1'b0}}, top_s3} * {{DIM_W{1'b0}}, dw_s3};
	assign bot_prod = {{DIM_W{1'b0}}, bot_s3} * {{DIM_W{1'b0}}, dw_s3};

	always_ff @(posedge clk) begin
		sw_s1    <= clamp_dim(src_w_q);
		sh_s1    <= clamp_dim(src_h_q);
		dw_s1    <= clamp_dim(dst_w_q);
		dh_s1    <= clamp_dim(dst_h_q);
		align_s1 <= align_q;
		padv_s1  <= argb_q ? fill_q : PAD_ZERO;
		argb_s1  <= argb_q;

		sw_s2    <= sw_s1;
		sh_s2    <= sh_s1;
		dw_s2    <= dw_s1;
		kw_s2    <= (dw_s1 < sw_s1) ? dw_s1 : sw_s1;
		rpad_s2  <= (dw_s1 > sw_s1) ? dw_s1 - sw_s1 : '0;
		crop_s2  <= dh_s1 < sh_s1;
		vdiff_s2 <= (dh_s1 < sh_s1) ? sh_s1 - dh_s1 : dh_s1 - sh_s1;
		kept_s2  <= (dh_s1 < sh_s1) ? dh_s1 : sh_s1;
		align_s2 <= align_s1;
		padv_s2  <= padv_s1;
		argb_s2  <= argb_s1;

		sw_s3       <= sw_s2;
		sh_s3       <= sh_s2;
		dw_s3       <= dw_s2;
		kw_m1_s3    <= kw_s2 - DIM_W'(1);
		rpad_s3     <= rpad_s2;
		first_s3    <= crop_s2 ? shift : '0;
		last_row_s3 <= (crop_s2 ? shift : '0) + kept_s2 - DIM_W'(1);
		top_s3      <= crop_s2 ? '0 : shift;
		bot_s3      <= crop_s2 ? '0 : vdiff_s2 - shift;
		padv_s3     <= padv_s2;
		argb_s3     <= argb_s2;

		top_cnt_s4 <= (top_prod > {{(2*DIM_W-CNT_W){1'b0}}, COUNT_MAX}) ?
			COUNT_MAX : top_prod[CNT_W-1:0];
		bot_cnt_s4 <= (bot_prod > {{(2*DIM_W-CNT_W){1'b0}}, COUNT_MAX}) ?
			COUNT_MAX : bot_prod[CNT_W-1:0];
	end

	assign geom.pad_value = padv_s3;
	assign geom.top_count = top_cnt_s4;
	assign geom.bot_count = bot_cnt_s4;
	assign geom.rpad      = rpad_s3;

	// classify the incoming pixel against the current raster position
	always_comb begin
		col_w = {{(DIM_W-POS_W){1'b0}}, col_q};
		row_w = {{(DIM_W-POS_W){1'b0}}, row_q};
		// a position left past a narrowed frame starts over
		c0  = (col_w >= sw_s3) ? '0 : col_w;
		r0a = (col_w >= sw_s3) ? row_w + DIM_W'(1) : row_w;
		r0  = (r0a >= sh_s3) ? '0 : r0a;

		top_nz  = top_s3 != '0;
		rpad_nz = rpad_s3 != '0;
		bot_nz  = bot_s3 != '0;

		keep_row = (r0 >= first_s3) && (r0 <= last_row_s3);
		keep_col = c0 <= kw_m1_s3;
		last_col = c0 == kw_m1_s3;
		last_row = r0 == last_row_s3;

		e.value     = argb_s3 ? pixel : {{(PIX_W-8){1'b0}}, pixel[7:0]};
		e.top       = (r0 == '0) && (c0 == '0) && top_nz;
		e.pix       = keep_row && keep_col;
		e.pix_done  = last_row && last_col && !rpad_nz && !bot_nz;
		e.rpad      = keep_row && keep_col && last_col && rpad_nz;
		e.rpad_done = last_row && !bot_nz;
		e.bot       = keep_row && keep_col && last_row && last_col && bot_nz;

		c1 = c0 + DIM_W'(1);
		r1 = r0 + DIM_W'(1);
	end

	assign pix_stall  = full || (settle_q != '0);
	assign accept     = pix_valid && !pix_stall;
	assign push       = accept && (e.top || e.pix);
	assign push_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c1 >= sw_s3) begin
				col_q <= '0;
				row_q <= (r1 >= sh_s3) ? '0 : r1[POS_W-1:0];
			end else begin
				col_q <= c1[POS_W-1:0];
				row_q <= r0[POS_W-1:0];
			end
		end
	end

endmodule

// ===== sv/rcpva_fifo.sv =====
module rcpva_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rcpva_pkg::entry_t push_entry,
	input  logic              pop,
	output rcpva_pkg::entry_t head,
	output logic              empty,
	output logic              full
);
	import rcpva_pkg::*;

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/rcpva_back.sv =====
module rcpva_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rcpva_pkg::geom_t            geom,
	input  rcpva_pkg::entry_t           head,
	input  logic                        empty,
	output logic                        pop,
	output logic                        run_valid,
	input  logic                        run_stall,
	output logic [rcpva_pkg::PIX_W-1:0] run_value,
	output logic [rcpva_pkg::CNT_W-1:0] run_count,
	output logic                        last_of_item,
	output logic                        frame_done
);
	import rcpva_pkg::*;

	entry_t           cur_q;
	logic [3:0]       rem_q;
	logic             valid_q;
	logic [PIX_W-1:0] value_q;
	logic [CNT_W-1:0] count_q;
	logic             last_q, done_q;

	logic             cur_vld, out_free, avail, load;
	entry_t           src;
	logic [3:0]       src_mask, sel, rest;
	logic [PIX_W-1:0] nxt_value;
	logic [CNT_W-1:0] nxt_count;
	logic             nxt_done;

	assign cur_vld  = rem_q != '0;
	assign out_free = !valid_q || !run_stall;
	assign avail    = cur_vld || !empty;
	assign load     = out_free && avail;
	assign pop      = load && !cur_vld;

	assign src      = cur_vld ? cur_q : head;
	assign src_mask = cur_vld ? rem_q : {head.bot, head.rpad, head.pix, head.top};
	assign sel      = src_mask & (~src_mask + 4'd1);
	assign rest     = src_mask & ~sel;

	always_comb begin
		case (sel)
			RUN_TOP: begin
				nxt_value = geom.pad_value;
				nxt_count = geom.top_count;
				nxt_done  = 1'b0;
			end
			RUN_PIX: begin
				nxt_value = src.value;
				nxt_count = CNT_W'(1);
				nxt_done  = src.pix_done;
			end
			RUN_RPAD: begin
				nxt_value = PAD_ZERO;
				nxt_count = {{(CNT_W-DIM_W){1'b0}}, geom.rpad};
				nxt_done  = src.rpad_done;
			end
			RUN_BOT: begin
				nxt_value = geom.pad_value;
				nxt_count = geom.bot_count;
				nxt_done  = 1'b1;
			end
			default: begin
				nxt_value = PAD_ZERO;
				nxt_count = CNT_W'(1);
				nxt_done  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			rem_q   <= rest;
			valid_q <= 1'b1;
		end else if (out_free) begin
			valid_q <= 1'b0;
		end
	end

	// hold payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (load) begin
			value_q <= nxt_value;
			count_q <= nxt_count;
			last_q  <= rest == '0;
			done_q  <= nxt_done;
		end
	end

	assign run_valid    = valid_q;
	assign run_value    = value_q;
	assign run_count    = count_q;
	assign last_of_item = last_q;
	assign frame_done   = done_q;

endmodule

// ===== sv/rcpva_checker.sv =====
`include "raster_crop_pad_vertical_align_assert.svh"

module rcpva_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        wr_en,
	input logic [rcpva_pkg::IDX_W-1:0] wr_index,
	input logic [rcpva_pkg::PIX_W-1:0] wr_data,
	input logic                        pix_valid,
	input logic                        pix_stall,
	input logic [rcpva_pkg::PIX_W-1:0] pixel,
	input logic                        run_valid,
	input logic                        run_stall,
	input logic [rcpva_pkg::PIX_W-1:0] run_value,
	input logic [rcpva_pkg::CNT_W-1:0] run_count,
	input logic                        last_of_item,
	input logic                        frame_done
);

	// a stalled run stays offered
	`RCPVA_ASSERT_NXT(a_run_hold, run_valid && run_stall, run_valid)
	// every run covers at least one pixel
	`RCPVA_ASSERT_IMP(a_run_nonzero, run_valid, run_count != '0)
	// the run closing the frame is the last one of its pixel
	`RCPVA_ASSERT_IMP(a_done_is_last, run_valid && frame_done, last_of_item)
	// a config write holds off the next pixel transfer
	`RCPVA_ASSERT_NXT(a_cfg_settle, wr_en, pix_stall)

endmodule

bind raster_crop_pad_vertical_align rcpva_checker u_rcpva_checker (.*);
